/* hdl/mau_pkg.sv */
// Package for the modular arithmetic unit: widths, opcodes and shared types.
`default_nettype none
package mau_pkg;

    localparam int RESIDUE_WIDTH  = 30;
    localparam int EXPONENT_WIDTH = 63;

    // exponent register also holds modulus minus two for inversion
    localparam int EXP_REG_W = (EXPONENT_WIDTH > RESIDUE_WIDTH) ? EXPONENT_WIDTH : RESIDUE_WIDTH;

    // bit counter of the shared multiplier, able to hold RESIDUE_WIDTH itself
    localparam int CNT_W = $clog2(RESIDUE_WIDTH + 1);

    localparam logic [RESIDUE_WIDTH-1:0] MODULUS_RESET = RESIDUE_WIDTH'(64'd1000000007);

    // opcodes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_NEG = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_INV = 3'd4;
    localparam logic [2:0] OP_DIV = 3'd5;
    localparam logic [2:0] OP_POW = 3'd6;

    // request to the shared modular multiplier: product = x * y mod m, x below m
    typedef struct packed {
        logic                     start;
        logic [RESIDUE_WIDTH-1:0] x;
        logic [RESIDUE_WIDTH-1:0] y;
    } t_mul_req;

    // finished result from the sequencer
    typedef struct packed {
        logic [RESIDUE_WIDTH-1:0] value;
        logic                     status;
    } t_res_beat;

endpackage
`default_nettype wire

/* hdl/mau_mulmod.sv */
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
`default_nettype none
module mau_mulmod (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire mau_pkg::t_mul_req              i_req,
    input  wire  [mau_pkg::RESIDUE_WIDTH-1:0]   i_mod,
    output logic                                o_done,
    output logic [mau_pkg::RESIDUE_WIDTH-1:0]   o_prod
);

    localparam int RW = mau_pkg::RESIDUE_WIDTH;
    localparam int CW = mau_pkg::CNT_W;

    logic [RW-1:0] r_acc;
    logic [RW-1:0] r_x;
    logic [RW-1:0] r_y;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [RW+1:0] w_t0;
    logic [RW+1:0] w_t1;
    logic [RW+1:0] w_t2;
    logic [RW+1:0] w_m;

    // acc = 2*acc + bit*x stays below 3m: at most two corrective subtractions
    always_comb begin
        w_m  = {2'b00, i_mod};
        w_t0 = {1'b0, r_acc, 1'b0} + (r_y[RW-1] ? {2'b00, r_x} : '0);
        w_t1 = (w_t0 >= w_m) ? (w_t0 - w_m) : w_t0;
        w_t2 = (w_t1 >= w_m) ? (w_t1 - w_m) : w_t1;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(RW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_x   <= i_req.x;
            r_y   <= i_req.y;
        end else if (r_busy) begin
            r_acc <= w_t2[RW-1:0];
            r_y   <= {r_y[RW-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

/* hdl/mau_seq.sv */
// Operation sequencer: operand reduction, simple ops and square-and-multiply.
`default_nettype none
module mau_seq (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  [mau_pkg::RESIDUE_WIDTH-1:0]   i_mod,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  [2:0]                          i_opcode,
    input  wire  [mau_pkg::RESIDUE_WIDTH-1:0]   i_operand_a,
    input  wire  [mau_pkg::RESIDUE_WIDTH-1:0]   i_operand_b,
    input  wire  [mau_pkg::EXPONENT_WIDTH-1:0]  i_exponent,
    input  wire                                 i_out_free,
    output logic                                o_res_valid,
    output mau_pkg::t_res_beat                  o_res,
    output mau_pkg::t_mul_req                   o_mul_req,
    input  wire                                 i_mul_done,
    input  wire  [mau_pkg::RESIDUE_WIDTH-1:0]   i_mul_prod
);

    localparam int RW = mau_pkg::RESIDUE_WIDTH;
    localparam int EW = mau_pkg::EXP_REG_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RED_A   = 4'd1;
    localparam logic [3:0] S_RED_B   = 4'd2;
    localparam logic [3:0] S_DISP    = 4'd3;
    localparam logic [3:0] S_POW_CHK = 4'd4;
    localparam logic [3:0] S_POW_MUL = 4'd5;
    localparam logic [3:0] S_POW_SQR = 4'd6;
    localparam logic [3:0] S_FIN_MUL = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]    r_state, n_state;
    logic [2:0]    r_op, n_op;
    logic [RW-1:0] r_a, n_a;
    logic [RW-1:0] r_b, n_b;
    logic [RW-1:0] r_base, n_base;
    logic [RW-1:0] r_acc, n_acc;
    logic [EW-1:0] r_e, n_e;
    logic [RW-1:0] r_res, n_res;
    logic          r_st, n_st;
    logic          r_start, n_start;
    logic [RW-1:0] r_mx, n_mx;
    logic [RW-1:0] r_my, n_my;

    logic [RW:0]   w_sum;
    logic [RW:0]   w_dif;
    logic [RW:0]   w_m1;

    // add and subtract for the ops done in the dispatch state
    always_comb begin
        w_m1  = {1'b0, i_mod};
        w_sum = {1'b0, r_a} + {1'b0, r_b};
        w_dif = (r_a >= r_b) ? ({1'b0, r_a} - {1'b0, r_b})
                             : ({1'b0, r_a} + w_m1 - {1'b0, r_b});
    end

    // next-state logic
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_a     = r_a;
        n_b     = r_b;
        n_base  = r_base;
        n_acc   = r_acc;
        n_e     = r_e;
        n_res   = r_res;
        n_st    = r_st;
        n_start = 1'b0;
        n_mx    = r_mx;
        n_my    = r_my;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op  = i_opcode;
                    n_a   = i_operand_a;
                    n_b   = i_operand_b;
                    n_e   = EW'(i_exponent);
                    n_res = '0;
                    n_st  = 1'b0;
                    if (i_mod < RW'(2)) begin
                        n_state = S_DONE;
                    end else begin
                        // reduce a as a * 1 mod m
                        n_start = 1'b1;
                        n_mx    = RW'(1);
                        n_my    = i_operand_a;
                        n_state = S_RED_A;
                    end
                end
            end
            S_RED_A: begin
                if (i_mul_done) begin
                    n_a     = i_mul_prod;
                    n_start = 1'b1;
                    n_mx    = RW'(1);
                    n_my    = r_b;
                    n_state = S_RED_B;
                end
            end
            S_RED_B: begin
                if (i_mul_done) begin
                    n_b     = i_mul_prod;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                n_acc   = RW'(1);
                unique case (r_op)
                    mau_pkg::OP_ADD: begin
                        n_res = (w_sum >= w_m1) ? RW'(w_sum - w_m1) : RW'(w_sum);
                    end
                    mau_pkg::OP_SUB: begin
                        n_res = RW'(w_dif);
                    end
                    mau_pkg::OP_NEG: begin
                        n_res = (r_a == '0) ? '0 : (i_mod - r_a);
                    end
                    mau_pkg::OP_MUL: begin
                        n_start = 1'b1;
                        n_mx    = r_b;
                        n_my    = r_a;
                        n_state = S_FIN_MUL;
                    end
                    mau_pkg::OP_INV: begin
                        if (r_a == '0) begin
                            n_st = 1'b1;
                        end else begin
                            n_base  = r_a;
                            n_e     = EW'(i_mod) - EW'(2);
                            n_state = S_POW_CHK;
                        end
                    end
                    mau_pkg::OP_DIV: begin
                        if (r_b == '0) begin
                            n_st = 1'b1;
                        end else begin
                            n_base  = r_b;
                            n_e     = EW'(i_mod) - EW'(2);
                            n_state = S_POW_CHK;
                        end
                    end
                    mau_pkg::OP_POW: begin
                        n_base  = r_a;
                        n_state = S_POW_CHK;
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
            end
            S_POW_CHK: begin
                priority if (r_e == '0) begin
                    if (r_op == mau_pkg::OP_DIV) begin
                        n_start = 1'b1;
                        n_mx    = r_a;
                        n_my    = r_acc;
                        n_state = S_FIN_MUL;
                    end else begin
                        n_res   = r_acc;
                        n_state = S_DONE;
                    end
                end else if (r_e[0]) begin
                    n_start = 1'b1;
                    n_mx    = r_base;
                    n_my    = r_acc;
                    n_state = S_POW_MUL;
                end else begin
                    n_start = 1'b1;
                    n_mx    = r_base;
                    n_my    = r_base;
                    n_state = S_POW_SQR;
                end
            end
            S_POW_MUL: begin
                if (i_mul_done) begin
                    n_acc   = i_mul_prod;
                    n_start = 1'b1;
                    n_mx    = r_base;
                    n_my    = r_base;
                    n_state = S_POW_SQR;
                end
            end
            S_POW_SQR: begin
                if (i_mul_done) begin
                    n_base  = i_mul_prod;
                    n_e     = r_e >> 1;
                    n_state = S_POW_CHK;
                end
            end
            S_FIN_MUL: begin
                if (i_mul_done) begin
                    n_res   = i_mul_prod;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_a    <= n_a;
        r_b    <= n_b;
        r_base <= n_base;
        r_acc  <= n_acc;
        r_e    <= n_e;
        r_res  <= n_res;
        r_st   <= n_st;
        r_mx   <= n_mx;
        r_my   <= n_my;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_res_valid     = (r_state == S_DONE) && i_out_free;
    assign o_res.value     = r_res;
    assign o_res.status    = r_st;
    assign o_mul_req.start = r_start;
    assign o_mul_req.x     = r_mx;
    assign o_mul_req.y     = r_my;

endmodule
`default_nettype wire

/* hdl/modular_arithmetic_unit.sv */
// Top level of the modular arithmetic unit: modulus register, sequencer, output register.
`default_nettype none
// Modular arithmetic over the modulus register (reset 1000000007, written through
// i_cfg_we/i_cfg_data; the user must write it only while the block is idle, as the
// block itself does not enforce this). Each accepted beat gives one result beat.
// Both residue operands are first reduced by the shared bit-serial multiplier, one
// multiplier bit per cycle. Add, subtract and negate are then computed in the
// dispatch state; multiply takes one more multiply. Power takes roughly (ones +
// bits of the exponent) multiplies, with bits counted up to the highest set bit:
// up to 126 multiplies for a 63-bit exponent. Inverse and divide run the same loop
// on modulus minus two (divide adds one multiply). A modulus below two skips the
// reductions and answers with result 0. The multiplier sets most of the run time.
// The input is taken again once the result sits in the output register, while
// that register waits for i_out_ready.
module modular_arithmetic_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [mau_pkg::RESIDUE_WIDTH-1:0]   i_cfg_data,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  [2:0]                          i_opcode,
    input  wire  [mau_pkg::RESIDUE_WIDTH-1:0]   i_operand_a,
    input  wire  [mau_pkg::RESIDUE_WIDTH-1:0]   i_operand_b,
    input  wire  [mau_pkg::EXPONENT_WIDTH-1:0]  i_exponent,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [mau_pkg::RESIDUE_WIDTH-1:0]   o_result,
    output logic                                o_status
);

    logic [mau_pkg::RESIDUE_WIDTH-1:0] r_mod;
    logic                              r_out_valid;
    logic [mau_pkg::RESIDUE_WIDTH-1:0] r_result;
    logic                              r_status;

    logic                              w_out_free;
    logic                              w_res_valid;
    mau_pkg::t_res_beat                w_res;
    mau_pkg::t_mul_req                 w_mul_req;
    logic                              w_mul_done;
    logic [mau_pkg::RESIDUE_WIDTH-1:0] w_mul_prod;

    // modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= mau_pkg::MODULUS_RESET;
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_data;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    mau_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mod       (r_mod),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_exponent  (i_exponent),
        .i_out_free  (w_out_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_mul_req   (w_mul_req),
        .i_mul_done  (w_mul_done),
        .i_mul_prod  (w_mul_prod)
    );

    mau_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .i_mod   (r_mod),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    // output register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register: payload
    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_result <= w_res.value;
            r_status <= w_res.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign o_status    = r_status;

endmodule
`default_nettype wire
